// ===== src/ptb_pkg.sv =====
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int POS_W       = 28;
    localparam int FRAC_W      = 16;
    localparam int CELL_W      = POS_W - 1 - FRAC_W;
    localparam int DIVISOR_W   = 9;
    localparam int ACROSS_W    = 11;
    localparam int TCOUNT_W    = 11;
    localparam int SPT_W       = 16;
    localparam int PROD_W      = ACROSS_W + CELL_W;
    localparam int TILE_W      = PROD_W + 1;
    localparam int OUT_W       = 20;
    localparam int WIDE_W      = 33;
    localparam int DIV_CNT_W   = $clog2(CELL_W + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_COUNT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOTS_PER_TILE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY     = 3'd5;

    localparam logic [DIVISOR_W-1:0] RST_TILE_WIDTH     = 9'd16;
    localparam logic [DIVISOR_W-1:0] RST_TILE_HEIGHT    = 9'd16;
    localparam logic [ACROSS_W-1:0]  RST_TILES_ACROSS   = 11'd16;
    localparam logic [TCOUNT_W-1:0]  RST_TILE_COUNT     = 11'd256;
    localparam logic [SPT_W-1:0]     RST_SLOTS_PER_TILE = 16'd1024;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] grid;
    } cell_t;

    typedef struct packed {
        logic [OUT_W-1:0] tile_index;
        logic [OUT_W-1:0] slot_index;
        logic             placed;
        logic             tile_out_of_range;
        logic             bad_position;
        logic [OUT_W-1:0] max_count;
        logic [OUT_W-1:0] overflow_amount;
        logic             batch_mismatch;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIVIDE,
        ST_SCALE,
        ST_SUM,
        ST_CHECK,
        ST_UPDATE,
        ST_REJECT,
        ST_FINISH
    } state_t;

    function automatic cell_t cell_of(input logic [POS_W-1:0] raw);
        cell_t c;
        c.ok   = 1'b1;
        c.grid = raw[POS_W-2:FRAC_W];
        if (raw[POS_W-1])
        begin
            c.grid = '0;
            c.ok   = (&raw[POS_W-1:FRAC_W]) && (|raw[FRAC_W-1:0]);
        end
        return c;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input wide_t v);
        return (v > wide_t'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

endpackage

// ===== src/ptb_count_ram.sv =====
`timescale 1ns / 1ps

module ptb_count_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 20
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ptb_divider.sv =====
`timescale 1ns / 1ps

module ptb_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0][ptb_pkg::CELL_W-1:0]     dividend,
    input  logic [1:0][ptb_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                busy,
    output logic [1:0][ptb_pkg::CELL_W-1:0]     quotient
);

    import ptb_pkg::*;

    localparam logic [DIV_CNT_W-1:0] STEPS = DIV_CNT_W'(CELL_W);

    logic [DIV_CNT_W-1:0]       count_reg, count_next;
    logic [1:0][DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [1:0][DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [1:0][CELL_W-1:0]     quo_reg, quo_next;
    logic [1:0][DIVISOR_W:0]    trial;
    logic [1:0][DIVISOR_W:0]    diff;

    always_comb
    begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial[i] = {rem_reg[i], quo_reg[i][CELL_W-1]};
            diff[i]  = trial[i] - {1'b0, divisor_reg[i]};
        end
        if (start)
        begin
            count_next   = STEPS;
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - DIV_CNT_W'(1);
            for (int i = 0; i < 2; i++)
            begin
                if (trial[i] >= {1'b0, divisor_reg[i]})
                begin
                    rem_next[i] = diff[i][DIVISOR_W-1:0];
                    quo_next[i] = {quo_reg[i][CELL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = trial[i][DIVISOR_W-1:0];
                    quo_next[i] = {quo_reg[i][CELL_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== src/particle_tile_binning_unit.sv =====
`timescale 1ns / 1ps
// A particle whose tile is in range passes the DIVIDE (the 11-step quotient loop), SCALE,
// SUM, CHECK and UPDATE states; the block takes no new item until it has registered the last result.
// An out-of-range tile gives its result from CHECK; a position of -1 or below goes to REJECT.
// A finish item gives its result and then clears the counter memory, one entry per cycle;
// the same clearing pass runs after reset, before the first input transfer. Reset restores
// all configuration registers to their defaults.

module particle_tile_binning_unit #(
    parameter int MAX_TILES  = 1024,
    parameter int COUNT_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [ptb_pkg::POS_W-1:0]    pos_x,
    input  logic signed [ptb_pkg::POS_W-1:0]    pos_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ptb_pkg::OUT_W-1:0]           tile_index,
    output logic [ptb_pkg::OUT_W-1:0]           slot_index,
    output logic                                placed,
    output logic                                tile_out_of_range,
    output logic                                bad_position,
    output logic [ptb_pkg::OUT_W-1:0]           max_count,
    output logic [ptb_pkg::OUT_W-1:0]           overflow_amount,
    output logic                                batch_mismatch,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import ptb_pkg::*;

    localparam int ADDR_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TILES - 1);
    localparam wide_t COUNT_MAX  = (wide_t'(1) << COUNT_BITS) - wide_t'(1);
    localparam wide_t TILE_LIMIT = wide_t'(MAX_TILES);

    state_t state_reg, state_next;

    logic [DIVISOR_W-1:0] tile_width_reg, tile_width_next;
    logic [DIVISOR_W-1:0] tile_height_reg, tile_height_next;
    logic [ACROSS_W-1:0]  tiles_across_reg, tiles_across_next;
    logic [TCOUNT_W-1:0]  tile_count_reg, tile_count_next;
    logic [SPT_W-1:0]     slots_per_tile_reg, slots_per_tile_next;
    logic                 count_only_reg, count_only_next;

    logic [COUNT_BITS-1:0] largest_reg, largest_next;
    logic [COUNT_BITS-1:0] worst_reg, worst_next;
    logic                  saw_bad_reg, saw_bad_next;
    logic [ADDR_W-1:0]     clear_addr_reg, clear_addr_next;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TILE_W-1:0] tile_reg, tile_next;

    result_t result_reg, result_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;

    cell_t cell_x, cell_y;

    logic                          div_start;
    logic [1:0][CELL_W-1:0]        div_dividend;
    logic [1:0][DIVISOR_W-1:0]     div_divisor;
    logic                          div_busy;
    logic [1:0][CELL_W-1:0]        div_quotient;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    wide_t limit_w, tile_w, tile_ovf_raw, tile_ovf;
    wide_t slot_w, spt_w, slot_ovf_raw, slot_ovf, slot_inc;
    logic  in_range, slot_fits;

    ptb_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    ptb_count_ram #(
        .DEPTH  (MAX_TILES),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_count_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign cell_x = cell_of(pos_x);
    assign cell_y = cell_of(pos_y);

    assign div_dividend   = {cell_y.grid, cell_x.grid};
    assign div_divisor[0] = (tile_width_reg == '0) ? DIVISOR_W'(1) : tile_width_reg;
    assign div_divisor[1] = (tile_height_reg == '0) ? DIVISOR_W'(1) : tile_height_reg;

    assign limit_w      = (wide_t'(tile_count_reg) < TILE_LIMIT) ?
                          wide_t'(tile_count_reg) : TILE_LIMIT;
    assign tile_w       = wide_t'(tile_reg);
    assign in_range     = (tile_w < limit_w);
    assign tile_ovf_raw = tile_w - limit_w + wide_t'(1);
    assign tile_ovf     = (tile_ovf_raw > COUNT_MAX) ? COUNT_MAX : tile_ovf_raw;

    assign slot_w       = wide_t'(rd_data);
    assign spt_w        = wide_t'(slots_per_tile_reg);
    assign slot_fits    = count_only_reg || (slot_w < spt_w);
    assign slot_ovf_raw = slot_w - spt_w + wide_t'(1);
    assign slot_ovf     = (slot_ovf_raw > COUNT_MAX) ? COUNT_MAX : slot_ovf_raw;
    assign slot_inc     = (slot_w == COUNT_MAX) ? slot_w : slot_w + wide_t'(1);

    assign out_free = !out_valid_reg || out_ready;
    assign rd_addr  = tile_reg[ADDR_W-1:0];
    assign wr_addr  = (state_reg == ST_CLEAR) ? clear_addr_reg : tile_reg[ADDR_W-1:0];

    always_comb
    begin
        tile_width_next     = tile_width_reg;
        tile_height_next    = tile_height_reg;
        tiles_across_next   = tiles_across_reg;
        tile_count_next     = tile_count_reg;
        slots_per_tile_next = slots_per_tile_reg;
        count_only_next     = count_only_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TILE_WIDTH:     tile_width_next     = cfg_data[DIVISOR_W-1:0];
                REG_TILE_HEIGHT:    tile_height_next    = cfg_data[DIVISOR_W-1:0];
                REG_TILES_ACROSS:   tiles_across_next   = cfg_data[ACROSS_W-1:0];
                REG_TILE_COUNT:     tile_count_next     = cfg_data[TCOUNT_W-1:0];
                REG_SLOTS_PER_TILE: slots_per_tile_next = cfg_data[SPT_W-1:0];
                REG_COUNT_ONLY:     count_only_next     = cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        div_start       = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = '0;
        largest_next    = largest_reg;
        worst_next      = worst_reg;
        saw_bad_next    = saw_bad_reg;
        clear_addr_next = clear_addr_reg;
        prod_next       = prod_reg;
        tile_next       = tile_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (cell_x.ok && cell_y.ok)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        saw_bad_next = 1'b1;
                        state_next   = ST_REJECT;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                prod_next  = PROD_W'(tiles_across_reg) * PROD_W'(div_quotient[1]);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                tile_next  = TILE_W'(div_quotient[0]) + TILE_W'(prod_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (in_range)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_UPDATE;
                end
                else if (out_free)
                begin
                    if (tile_ovf > wide_t'(worst_reg))
                    begin
                        worst_next = tile_ovf[COUNT_BITS-1:0];
                    end
                    result_next                   = '0;
                    result_next.tile_index        = sat_out(tile_w);
                    result_next.tile_out_of_range = 1'b1;
                    out_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    wr_en   = 1'b1;
                    wr_data = slot_inc[COUNT_BITS-1:0];
                    if (slot_inc > wide_t'(largest_reg))
                    begin
                        largest_next = slot_inc[COUNT_BITS-1:0];
                    end
                    if (!slot_fits && (slot_ovf > wide_t'(worst_reg)))
                    begin
                        worst_next = slot_ovf[COUNT_BITS-1:0];
                    end
                    result_next            = '0;
                    result_next.tile_index = sat_out(tile_w);
                    result_next.slot_index = sat_out(slot_w);
                    result_next.placed     = slot_fits;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    result_next              = '0;
                    result_next.bad_position = 1'b1;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_next                 = '0;
                    result_next.max_count       = sat_out(wide_t'(largest_reg));
                    result_next.overflow_amount = sat_out(wide_t'(worst_reg));
                    result_next.batch_mismatch  = saw_bad_reg && (worst_reg == '0);
                    out_valid_next              = 1'b1;
                    largest_next                = '0;
                    worst_next                  = '0;
                    saw_bad_next                = 1'b0;
                    clear_addr_next             = '0;
                    state_next                  = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clear_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clear_addr_reg     <= '0;
            largest_reg        <= '0;
            worst_reg          <= '0;
            saw_bad_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            tile_width_reg     <= RST_TILE_WIDTH;
            tile_height_reg    <= RST_TILE_HEIGHT;
            tiles_across_reg   <= RST_TILES_ACROSS;
            tile_count_reg     <= RST_TILE_COUNT;
            slots_per_tile_reg <= RST_SLOTS_PER_TILE;
            count_only_reg     <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            clear_addr_reg     <= clear_addr_next;
            largest_reg        <= largest_next;
            worst_reg          <= worst_next;
            saw_bad_reg        <= saw_bad_next;
            out_valid_reg      <= out_valid_next;
            tile_width_reg     <= tile_width_next;
            tile_height_reg    <= tile_height_next;
            tiles_across_reg   <= tiles_across_next;
            tile_count_reg     <= tile_count_next;
            slots_per_tile_reg <= slots_per_tile_next;
            count_only_reg     <= count_only_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        tile_reg   <= tile_next;
        result_reg <= result_next;
    end

    assign cfg_ready         = 1'b1;
    assign out_valid         = out_valid_reg;
    assign tile_index        = result_reg.tile_index;
    assign slot_index        = result_reg.slot_index;
    assign placed            = result_reg.placed;
    assign tile_out_of_range = result_reg.tile_out_of_range;
    assign bad_position      = result_reg.bad_position;
    assign max_count         = result_reg.max_count;
    assign overflow_amount   = result_reg.overflow_amount;
    assign batch_mismatch    = result_reg.batch_mismatch;

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=>
        (state_reg == ST_CLEAR && largest_reg == '0 && worst_reg == '0 && !saw_bad_reg))
        else $error("Finish did not clear the batch state.");

    a_quotient_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> !div_busy)
        else $error("Quotient used while the divider is still running.");

    a_placed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(placed && (tile_out_of_range || bad_position)))
        else $error("A placed particle carries an error flag.");

    a_mismatch_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && batch_mismatch) |-> (overflow_amount == '0))
        else $error("Batch mismatch reported together with an overflow.");

endmodule
